@@ hdl/sqma_pkg.sv @@
// Package for the symmetric quaternion minimum-angle block.
// Holds widths, register codes and the arctangent table; no dependencies.
package sqma_pkg;
  localparam int MaxEquiv = 16;
  localparam int CompBits = 16;
  localparam int Cb = (CompBits > 16) ? 16 : CompBits;
  localparam int Frac = Cb - 2;
  localparam int CordicSteps = 18;
  localparam int IdxW = $clog2(MaxEquiv);

  localparam logic [0:0] RegEquivCount = 1'b0;

  function automatic logic [17:0] atan_lut(input logic [4:0] i);
    logic [17:0] r;
    case (i)
      5'd0: r = 18'd131072;
      5'd1: r = 18'd77376;
      5'd2: r = 18'd40884;
      5'd3: r = 18'd20753;
      5'd4: r = 18'd10417;
      5'd5: r = 18'd5213;
      5'd6: r = 18'd2607;
      5'd7: r = 18'd1304;
      5'd8: r = 18'd652;
      5'd9: r = 18'd326;
      5'd10: r = 18'd163;
      5'd11: r = 18'd81;
      5'd12: r = 18'd41;
      5'd13: r = 18'd20;
      5'd14: r = 18'd10;
      5'd15: r = 18'd5;
      5'd16: r = 18'd3;
      5'd17: r = 18'd1;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

  // Sign-extended component k (0 = w) of a packed quaternion.
  function automatic logic signed [15:0] lane(input logic [63:0] q, input logic [1:0] k);
    logic [15:0] v;
    logic [15:0] r;
    v = q[48 - 16 * k +: 16];
    for (int b = 0; b < 16; b++) r[b] = (b < Cb) ? v[b] : v[Cb - 1];
    return $signed(r);
  endfunction
endpackage

@@ hdl/symmetric_quat_min_angle_top.sv @@
// Top level of the symmetric quaternion minimum-angle block.
// Uses sqma_pkg and sqma_ram.
//
//  channel | signals                                   | direction
//  in      | in_valid_i, in_stall_o, kind..test_quat   | input transactions
//  out     | out_valid_o, out_stall_i, angle_o         | result transactions
//  cfg     | APB psel/penable/pwrite/paddr/pwdata      | equiv_count register
//
// Loads can follow back to back. A compute uses one
// shared 16x16 multiplier: a read, 16 products for u, 4 for the test dot, per entry a read,
// 16 products and 4 for the dot, then a setup step, 29 root steps, 18 CORDIC steps and an output
// step; the entry work repeats for n = equiv_count entries, clamped to 16.
// Reset is asynchronous and clears control state only. The input is stalled while a
// compute is in work; a waiting result holds only the next compute in its output cycle.
module symmetric_quat_min_angle_top
  import sqma_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [3:0]  entry_index_i,
  input  logic [63:0] entry_quat_i,
  input  logic [63:0] ref_quat_i,
  input  logic [63:0] test_quat_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] angle_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_UMUL, S_QDOT, S_RDE, S_PMUL, S_PDOT, S_SQ0, S_SQRT, S_CORD, S_OUT
  } state_e;

  state_e state_q;
  logic [4:0] cnt_q;
  logic [4:0] step_q;
  logic [4:0] equiv_count_q;
  logic [63:0] ref_q, test_q, u_q, p_q, e_q;
  logic signed [35:0] acc_q;
  logic signed [35:0] best_q;
  logic [57:0] rem_q, root_q;
  logic signed [31:0] cx_q, cy_q;
  logic signed [20:0] cz_q;
  logic neg_q;
  logic [15:0] angle_q;
  logic out_valid_q;

  assign pready = 1'b1;
  assign prdata = {27'd0, equiv_count_q};
  wire cfg_wr = psel && penable && pwrite && (paddr[1:0] == {RegEquivCount, 1'b0});

  wire [4:0] n_used = (equiv_count_q > 5'(MaxEquiv)) ? 5'(MaxEquiv) : equiv_count_q;

  // The output register can take a new result when it is empty or being drained.
  wire out_free = !out_valid_q || !out_stall_i;

  // Table RAM.
  logic ram_we;
  logic [IdxW-1:0] ram_ra;
  logic [63:0] ram_rd;
  assign ram_we = in_valid_i && !in_stall_o && !kind_i && ({1'b0, entry_index_i} < 5'(MaxEquiv));
  sqma_ram #(.Width(64), .Depth(MaxEquiv)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(entry_index_i[IdxW-1:0]), .wdata_i(entry_quat_i),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );
  assign ram_ra = (state_q == S_IDLE) ? '0 : cnt_q[IdxW-1:0];

  // Product term selection: output comp o = step[3:2], term t = step[1:0].
  // a index = t; b index and sign per Hamilton product table.
  logic [1:0] bi;
  logic sub;
  always_comb begin
    bi = 2'd0; sub = 1'b0;
    case (step_q[3:0])
      4'd0: begin bi = 2'd0; sub = 1'b0; end
      4'd1: begin bi = 2'd1; sub = 1'b1; end
      4'd2: begin bi = 2'd2; sub = 1'b1; end
      4'd3: begin bi = 2'd3; sub = 1'b1; end
      4'd4: begin bi = 2'd1; sub = 1'b0; end
      4'd5: begin bi = 2'd0; sub = 1'b0; end
      4'd6: begin bi = 2'd3; sub = 1'b0; end
      4'd7: begin bi = 2'd2; sub = 1'b1; end
      4'd8: begin bi = 2'd2; sub = 1'b0; end
      4'd9: begin bi = 2'd3; sub = 1'b1; end
      4'd10: begin bi = 2'd0; sub = 1'b0; end
      4'd11: begin bi = 2'd1; sub = 1'b0; end
      4'd12: begin bi = 2'd3; sub = 1'b0; end
      4'd13: begin bi = 2'd2; sub = 1'b0; end
      4'd14: begin bi = 2'd1; sub = 1'b1; end
      default: begin bi = 2'd0; sub = 1'b0; end
    endcase
  end

  // Shared multiplier operands.
  logic signed [15:0] ma, mb;
  logic msub;
  always_comb begin
    ma = '0; mb = '0; msub = 1'b0;
    case (state_q)
      S_UMUL: begin
        ma = lane(test_q, step_q[1:0]);
        mb = lane(e_q, bi);
        // conj(e0): negate vector components of b.
        msub = sub ^ (bi != 2'd0);
      end
      S_PMUL: begin
        // The table entry stays on the RAM output while its address holds.
        ma = lane(u_q, step_q[1:0]);
        mb = lane(ram_rd, bi);
        msub = sub;
      end
      S_QDOT: begin ma = lane(test_q, step_q[1:0]); mb = lane(ref_q, step_q[1:0]); end
      S_PDOT: begin ma = lane(p_q, step_q[1:0]); mb = lane(ref_q, step_q[1:0]); end
      default: ;
    endcase
  end
  wire signed [31:0] prod = ma * mb;
  wire signed [35:0] acc_n = msub ? acc_q - 36'(prod) : acc_q + 36'(prod);

  // Round and saturate a finished product component.
  logic signed [35:0] rnd;
  logic [15:0] narrowed;
  always_comb begin
    rnd = (acc_n + 36'(1 <<< (Frac - 1))) >>> Frac;
    if (rnd > 36'((1 <<< (Cb - 1)) - 1)) narrowed = 16'((1 <<< (Cb - 1)) - 1);
    else if (rnd < -36'(1 <<< (Cb - 1))) narrowed = 16'(-(1 <<< (Cb - 1)));
    else narrowed = rnd[15:0];
  end

  localparam logic signed [35:0] One = 36'(1) <<< (2 * Frac);
  wire signed [35:0] dclamp = (acc_n > One) ? One : ((acc_n < -One) ? -One : acc_n);

  // Square root digit step on a radicand with 56 fraction bits.
  wire [57:0] sq_bit = 58'd1 << {step_q, 1'b0};
  wire [57:0] sq_try = root_q + sq_bit;
  wire sq_take = rem_q >= sq_try;
  wire [57:0] root_n = sq_take ? (root_q >> 1) + sq_bit : root_q >> 1;
  // CORDIC step.
  wire signed [31:0] xs = cx_q >>> step_q;
  wire signed [31:0] ys = cy_q >>> step_q;
  wire signed [20:0] at = $signed({3'd0, atan_lut(step_q)});
  wire signed [20:0] zc = (cz_q < 0) ? 21'sd0 : ((cz_q > 21'sd262144) ? 21'sd262144 : cz_q);
  wire [16:0] rr0 = 17'((zc + 21'sd8) >>> 4);
  wire [15:0] rr = (rr0 > 17'd16384) ? 16'd16384 : rr0[15:0];

  wire [35:0] best_abs = best_q[35] ? 36'(-best_q) : 36'(best_q);
  wire [57:0] a28 = 58'(best_abs) << (28 - 2 * Frac);
  wire [28:0] a_abs = a28[28:0];
  wire [57:0] a_sq = a_abs * a_abs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      step_q <= '0;
      equiv_count_q <= 5'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) equiv_count_q <= pwdata[4:0];
      if (state_q == S_OUT && out_free) begin
        angle_q <= neg_q ? 16'(17'd32768 - {1'b0, rr}) : rr;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o && kind_i) begin
            ref_q <= ref_quat_i;
            test_q <= test_quat_i;
            cnt_q <= '0;
            state_q <= S_RD0;
          end
        end
        S_RD0: begin
          e_q <= ram_rd;
          step_q <= '0; acc_q <= '0;
          state_q <= S_UMUL;
        end
        S_UMUL: begin
          if (step_q[1:0] == 2'd3) begin
            u_q[48 - 16 * step_q[3:2] +: 16] <= narrowed;
            acc_q <= '0;
          end else acc_q <= acc_n;
          if (step_q == 5'd15) begin step_q <= '0; state_q <= S_QDOT; end
          else step_q <= step_q + 5'd1;
        end
        S_QDOT: begin
          if (step_q == 5'd3) begin
            best_q <= dclamp; acc_q <= '0; step_q <= '0;
            state_q <= (n_used == 5'd0) ? S_SQ0 : S_RDE;
          end else begin acc_q <= acc_n; step_q <= step_q + 5'd1; end
        end
        S_RDE: state_q <= S_PMUL;
        S_PMUL: begin
          if (step_q[1:0] == 2'd3) begin
            p_q[48 - 16 * step_q[3:2] +: 16] <= narrowed;
            acc_q <= '0;
          end else acc_q <= acc_n;
          if (step_q == 5'd15) begin step_q <= '0; state_q <= S_PDOT; end
          else step_q <= step_q + 5'd1;
        end
        S_PDOT: begin
          if (step_q == 5'd3) begin
            if (dclamp > best_q) best_q <= dclamp;
            acc_q <= '0; step_q <= '0;
            if (cnt_q + 5'd1 >= n_used) begin
              state_q <= S_SQ0;
            end else begin
              cnt_q <= cnt_q + 5'd1; state_q <= S_RDE;
            end
          end else begin acc_q <= acc_n; step_q <= step_q + 5'd1; end
        end
        S_SQ0: begin
          rem_q <= (58'd1 << 56) - a_sq;
          root_q <= '0;
          neg_q <= best_q[35];
          step_q <= 5'd28;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_take) rem_q <= rem_q - sq_try;
          root_q <= root_n;
          if (step_q == 5'd0) begin
            cx_q <= 32'(a_abs);
            cy_q <= root_n[31:0];
            cz_q <= '0;
            state_q <= S_CORD;
          end else step_q <= step_q - 5'd1;
        end
        S_CORD: begin
          if (cy_q >= 0) begin
            cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
          end else begin
            cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
          end
          if (step_q == 5'(CordicSteps - 1)) state_q <= S_OUT;
          else step_q <= step_q + 5'd1;
        end
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign angle_o = angle_q;
endmodule

@@ hdl/sqma_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module sqma_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
